### src/hpack_header_block_decoder_top_defines.svh
// Assertion macros used by the header block decoder back end.
// Uses clk and rst_n of the including module.
`ifndef HPACK_HEADER_BLOCK_DECODER_TOP_DEFINES_SVH
`define HPACK_HEADER_BLOCK_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define HBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/hbd_pkg.sv
// Package for the HPACK header block decoder: payload types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps

package hbd_pkg;

  localparam int unsigned STATIC_ENTRIES = 61;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_INDEXED = 2'd1;
  localparam logic [1:0] KIND_SIZE    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  localparam logic [7:0] CFG_MAX_TABLE_BYTES = 8'd0;
  localparam logic [7:0] CFG_FIELD_LIMIT     = 8'd1;

  localparam logic [31:0] MAX_TABLE_BYTES_RST = 32'd4096;
  localparam logic [15:0] FIELD_LIMIT_RST     = 16'd256;

  localparam logic [7:0] INDEXED_MASK   = 8'h80;
  localparam logic [7:0] SIZE_MASK      = 8'hE0;
  localparam logic [7:0] SIZE_CODE      = 8'h20;
  localparam logic [6:0] PREFIX7_ONES   = 7'h7F;
  localparam logic [4:0] PREFIX5_ONES   = 5'h1F;
  localparam logic [5:0] SHIFT_STEP     = 6'd7;
  localparam logic [5:0] SHIFT_LIMIT    = 6'd56;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] decoded_value;
    logic [1:0]  status;
    logic        block_end;
    logic [15:0] fields_decoded;
  } out_item_t;

  // classified byte as held in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_last;
    logic       is_indexed;
    logic       is_size;
    logic       pfx7_full;
    logic       pfx5_full;
  } hbd_item_t;

endpackage

### src/hbd_front.sv
// Front classifier: tags each header byte with its representation class.
// Depends on hbd_pkg.
`timescale 1ns / 1ps

module hbd_front import hbd_pkg::*; (
  input  in_item_t  in_item,
  output hbd_item_t cls_item
);

  always_comb begin
    cls_item.data_byte  = in_item.data_byte;
    cls_item.block_last = in_item.block_last;
    cls_item.is_indexed = (in_item.data_byte & INDEXED_MASK) != 8'd0;
    cls_item.is_size    = (in_item.data_byte & SIZE_MASK) == SIZE_CODE;
    cls_item.pfx7_full  = in_item.data_byte[6:0] == PREFIX7_ONES;
    cls_item.pfx5_full  = in_item.data_byte[4:0] == PREFIX5_ONES;
  end

endmodule

### src/hbd_fifo.sv
// Two-entry queue between the classifier and the decode back end.
// Depends on hbd_pkg.
`timescale 1ns / 1ps

module hbd_fifo import hbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  hbd_item_t push_item,
  output logic      not_full,
  input  logic      pop,
  output logic      not_empty,
  output hbd_item_t pop_item
);

  hbd_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign not_full  = count_r != 2'd2;
  assign not_empty = count_r != 2'd0;
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = 2'(count_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/hbd_back.sv
// Decode back end: prefix-integer state, limits, config registers, output register.
// Depends on hbd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "hpack_header_block_decoder_top_defines.svh"

module hbd_back import hbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic       q_valid,
  input  hbd_item_t  q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  logic [31:0] max_table_r;
  logic [15:0] field_limit_r;

  logic        in_int_r, in_int_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [5:0]  shift_r, shift_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [15:0] hdone_r, hdone_nxt;
  logic        aband_r, aband_nxt;
  logic [1:0]  bstat_r, bstat_nxt;

  logic        out_valid_r;
  out_item_t   out_data_r, res_item;
  logic        emit;

  logic [6:0]  low7;
  logic [63:0] add_v;
  logic [64:0] sum_v;
  logic [5:0]  shift_inc;
  logic        do_finish, do_fail;
  logic [1:0]  fin_kind, fail_code;
  logic [63:0] fin_val;
  logic        res_have;
  logic [1:0]  res_kind, res_stat;
  logic [63:0] res_val;

  logic        blk_clean;
  logic        mid_res;
  logic        mid_agree;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    low7      = q_item.data_byte[6:0];
    add_v     = {57'd0, low7} << shift_r;
    sum_v     = {1'b0, acc_r} + {1'b0, add_v};
    shift_inc = 6'(shift_r + SHIFT_STEP);

    in_int_nxt = in_int_r;
    acc_nxt    = acc_r;
    shift_nxt  = shift_r;
    pend_nxt   = pend_r;
    hdone_nxt  = hdone_r;
    aband_nxt  = aband_r;
    bstat_nxt  = bstat_r;
    do_finish  = 1'b0;
    do_fail    = 1'b0;
    fin_kind   = KIND_NONE;
    fin_val    = 64'd0;
    fail_code  = ST_OK;
    res_have   = 1'b0;
    res_kind   = KIND_NONE;
    res_val    = 64'd0;
    res_stat   = ST_OK;

    if (!aband_r) begin
      if (in_int_r) begin
        acc_nxt = sum_v[63:0];
        if (sum_v[64]) begin
          do_fail   = 1'b1;
          fail_code = ST_INVALID;
        end else if (!q_item.data_byte[7]) begin
          do_finish = 1'b1;
          fin_kind  = pend_r;
          fin_val   = sum_v[63:0];
        end else begin
          shift_nxt = shift_inc;
          if (shift_inc > SHIFT_LIMIT) begin
            do_fail   = 1'b1;
            fail_code = ST_INVALID;
          end
        end
      end else if (hdone_r >= field_limit_r) begin
        aband_nxt = 1'b1;
      end else if (q_item.is_indexed) begin
        if (!q_item.pfx7_full) begin
          do_finish = 1'b1;
          fin_kind  = KIND_INDEXED;
          fin_val   = {57'd0, low7};
        end else begin
          in_int_nxt = 1'b1;
          acc_nxt    = {57'd0, low7};
          shift_nxt  = 6'd0;
          pend_nxt   = KIND_INDEXED;
        end
      end else if (q_item.is_size) begin
        if (!q_item.pfx5_full) begin
          do_finish = 1'b1;
          fin_kind  = KIND_SIZE;
          fin_val   = {59'd0, q_item.data_byte[4:0]};
        end else begin
          in_int_nxt = 1'b1;
          acc_nxt    = {59'd0, q_item.data_byte[4:0]};
          shift_nxt  = 6'd0;
          pend_nxt   = KIND_SIZE;
        end
      end else begin
        do_fail   = 1'b1;
        fail_code = ST_INVALID;
      end
    end

    if (do_finish) begin
      in_int_nxt = 1'b0;
      if (fin_kind == KIND_INDEXED) begin
        if (fin_val == 64'd0 || fin_val > 64'(STATIC_ENTRIES)) begin
          do_fail   = 1'b1;
          fail_code = ST_INVALID;
        end else begin
          hdone_nxt = 16'(hdone_r + 16'd1);
        end
      end else if (fin_val > {32'd0, max_table_r}) begin
        do_fail   = 1'b1;
        fail_code = ST_TOO_LARGE;
      end
      if (!do_fail) begin
        res_have = 1'b1;
        res_kind = fin_kind;
        res_val  = fin_val;
      end
    end

    if (do_fail) begin
      bstat_nxt  = fail_code;
      aband_nxt  = 1'b1;
      in_int_nxt = 1'b0;
      res_have   = 1'b1;
      res_kind   = KIND_NONE;
      res_val    = 64'd0;
      res_stat   = fail_code;
    end

    res_item.kind           = res_kind;
    res_item.decoded_value  = res_val;
    res_item.fields_decoded = hdone_nxt;
    res_item.block_end      = q_item.block_last;
    emit                    = res_have;
    res_item.status         = res_stat;

    if (q_item.block_last) begin
      emit            = 1'b1;
      res_item.status = (!aband_nxt && in_int_nxt) ? ST_TRUNCATED : bstat_nxt;
      in_int_nxt = 1'b0;
      acc_nxt    = 64'd0;
      shift_nxt  = 6'd0;
      pend_nxt   = KIND_NONE;
      hdone_nxt  = 16'd0;
      aband_nxt  = 1'b0;
      bstat_nxt  = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_table_r   <= MAX_TABLE_BYTES_RST;
      field_limit_r <= FIELD_LIMIT_RST;
      in_int_r      <= 1'b0;
      acc_r         <= 64'd0;
      shift_r       <= 6'd0;
      pend_r        <= KIND_NONE;
      hdone_r       <= 16'd0;
      aband_r       <= 1'b0;
      bstat_r       <= ST_OK;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == CFG_MAX_TABLE_BYTES) begin
        max_table_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == CFG_FIELD_LIMIT) begin
        field_limit_r <= cfg_data[15:0];
      end
      if (q_pop) begin
        in_int_r <= in_int_nxt;
        acc_r    <= acc_nxt;
        shift_r  <= shift_nxt;
        pend_r   <= pend_nxt;
        hdone_r  <= hdone_nxt;
        aband_r  <= aband_nxt;
        bstat_r  <= bstat_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_data_r <= res_item;
    end
  end

  assign blk_clean = !in_int_r && !aband_r && (hdone_r == 16'd0) && (bstat_r == ST_OK);
  assign mid_res   = out_valid_r && !out_data_r.block_end;
  assign mid_agree = (out_data_r.kind == KIND_NONE) == (out_data_r.status != ST_OK);

  `HBD_ASSERT_NEXT(a_block_clears, q_pop && q_item.block_last, blk_clean, "block state not cleared")
  `HBD_ASSERT_NOW(a_aband_idle, aband_r, !in_int_r, "integer still open after abandon")
  `HBD_ASSERT_NOW(a_shift_range, in_int_r, shift_r <= SHIFT_LIMIT, "shift beyond limit")
  `HBD_ASSERT_NOW(a_mid_result, mid_res, mid_agree, "mid-block kind and status disagree")

endmodule

### src/hpack_header_block_decoder_top.sv
// Top level of the HPACK header block decoder (prefix-integer part).
// Depends on hbd_pkg, hbd_front, hbd_fifo and hbd_back.
//
// Usage:
//   in_*  : one header-block byte per transaction, block_last on the final byte.
//   out_* : zero or one result per byte; always one on a block's last byte.
//   cfg_* : register writes, index 0 max table size, 1 header field limit; other
//           indexes are ignored. cfg_ready is always high. Write only while idle.
// Timing:
//   One byte per cycle sustained while out_ready is high. A byte is written
//   into the two-entry queue at the accepting edge and decoded from there
//   (a 64-bit shift-add with carry check followed by the index or size
//   compare) into the output register, which raises out_valid when the byte
//   yields a result.
// Reset (rst_n low, synchronous): queue empties, all block state clears,
//   the max table size returns to 4096 and the header field limit to 256.
// Stall: while out_ready is low the output register holds its transaction,
//   the back end stops, the queue fills and in_ready drops once both entries
//   are used; no transaction is lost.
`timescale 1ns / 1ps

module hpack_header_block_decoder_top import hbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  hbd_item_t cls_item;
  hbd_item_t q_item;
  logic      q_not_full;
  logic      q_valid;
  logic      q_pop;

  assign in_ready  = q_not_full;
  assign cfg_ready = 1'b1;

  hbd_front u_front (
    .in_item  (in_data),
    .cls_item (cls_item)
  );

  hbd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && q_not_full),
    .push_item (cls_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  hbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
